// File: hdl/swka_pkg.sv
package swka_pkg;

  // fixed field widths
  localparam int TIME_W   = 48;
  localparam int GRP_IN_W = 4;
  localparam int MEM_IN_W = 8;
  localparam int AMT_W    = 10;
  localparam int WL_W     = 32;
  localparam int DM_W     = 9;
  localparam int GT_W     = 20;

  // parameter defaults
  localparam int EVENT_DEPTH_DEFAULT = 1024;
  localparam int GROUPS_DEFAULT      = 16;
  localparam int MEMBERS_DEFAULT     = 256;

  localparam logic [WL_W-1:0] WINDOW_RESET = 32'd86400;

  // controller to datapath
  typedef struct packed {
    logic clr;       // clearing pass write
    logic accept;    // latch input beat
    logic add_rd;    // read tables at the item
    logic add_wr;    // add booking, push fifo
    logic fifo_rd;   // read fifo front
    logic tag_rd;    // read tables at the front event
    logic exp_wr;    // retire front event
    logic fin_rd;    // read group entry of the item
    logic out_load;  // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_query;
    logic in_ok;
    logic fifo_full;
    logic fifo_empty;
    logic expire;
    logic clr_last;
  } status_t;

endpackage

// File: hdl/swka_in_if.sv
interface swka_in_if;
  import swka_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [TIME_W-1:0]   event_time;
  logic [GRP_IN_W-1:0] group;
  logic [MEM_IN_W-1:0] member;
  logic [AMT_W-1:0]    amount;

  modport source (output valid, kind, event_time, group, member, amount, input ready);
  modport sink (input valid, kind, event_time, group, member, amount, output ready);

endinterface

// File: hdl/swka_out_if.sv
interface swka_out_if;
  import swka_pkg::*;

  logic            valid;
  logic            ready;
  logic [DM_W-1:0] distinct_members;
  logic [GT_W-1:0] group_total;
  logic            dropped;

  modport source (output valid, distinct_members, group_total, dropped, input ready);
  modport sink (input valid, distinct_members, group_total, dropped, output ready);

endinterface

// File: hdl/sliding_window_key_aggregator.sv
// sequence: a query goes from the accepted beat to the group read and the result load;
//   a booking is added unless dropped or out of range, then expired front events are
//   retired until the front is still inside the window or the fifo is empty
// throughput: one item at a time, the next beat is taken in the cycle after the result
//   is loaded; the expiry loop over the tables sets the booking cost
// reset: asynchronous, active low; then a clearing pass clears the member and group
//   tables, GROUPS*MEMBERS entries (4096 by default), before the first beat is taken
module sliding_window_key_aggregator #(
  parameter int EVENT_DEPTH = swka_pkg::EVENT_DEPTH_DEFAULT,
  parameter int GROUPS      = swka_pkg::GROUPS_DEFAULT,
  parameter int MEMBERS     = swka_pkg::MEMBERS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swka_pkg::WL_W-1:0] cfg_wdata_i,
  swka_in_if.sink                   evt_i,
  swka_out_if.source                res_o
);
  import swka_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t st;

  // sequencer: clearing pass, add, expiry loop, result load
  swka_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (evt_i.valid),
    .in_ready_o  (evt_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // datapath: event fifo, member and group tables, window register, result register
  swka_dp #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .GROUPS      (GROUPS),
    .MEMBERS     (MEMBERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_kind_i     (evt_i.kind),
    .in_time_i     (evt_i.event_time),
    .in_group_i    (evt_i.group),
    .in_member_i   (evt_i.member),
    .in_amount_i   (evt_i.amount),
    .cmd_i         (cmd),
    .st_o          (st),
    .res_members_o (res_o.distinct_members),
    .res_total_o   (res_o.group_total),
    .res_dropped_o (res_o.dropped)
  );

endmodule

// File: hdl/swka_ctrl.sv
module swka_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  swka_pkg::status_t st_i,
  output swka_pkg::cmd_t    cmd_o
);
  import swka_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EXP_CHK,
    ST_EXP_CMP,
    ST_EXP_WR,
    ST_FIN_RD,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.accept = 1'b1;
          if (st_i.in_query) state_d = ST_FIN_RD;
          else if (st_i.in_ok && !st_i.fifo_full) state_d = ST_ADD_RD;
          else state_d = ST_EXP_CHK;
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (st_i.fifo_empty) begin
          state_d = ST_FIN_RD;
        end else begin
          cmd_o.fifo_rd = 1'b1;
          state_d       = ST_EXP_CMP;
        end
      end
      ST_EXP_CMP: begin
        cmd_o.tag_rd = 1'b1;
        state_d      = st_i.expire ? ST_EXP_WR : ST_FIN_RD;
      end
      ST_EXP_WR: begin
        cmd_o.exp_wr = 1'b1;
        state_d      = ST_EXP_CHK;
      end
      ST_FIN_RD: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result loaded over a pending beat");

  // nothing is accepted during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_fire)
    else $error("input accepted while clearing");

  // a new item follows only after the previous result went to the output
  a_accept_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && $past(state_q) == ST_FIN) |-> out_valid_q)
    else $error("accept without prior result load");

endmodule

// File: hdl/swka_dp.sv
module swka_dp #(
  parameter int EVENT_DEPTH = swka_pkg::EVENT_DEPTH_DEFAULT,
  parameter int GROUPS      = swka_pkg::GROUPS_DEFAULT,
  parameter int MEMBERS     = swka_pkg::MEMBERS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swka_pkg::WL_W-1:0]     cfg_wdata_i,
  input  logic                          in_kind_i,
  input  logic [swka_pkg::TIME_W-1:0]   in_time_i,
  input  logic [swka_pkg::GRP_IN_W-1:0] in_group_i,
  input  logic [swka_pkg::MEM_IN_W-1:0] in_member_i,
  input  logic [swka_pkg::AMT_W-1:0]    in_amount_i,
  input  swka_pkg::cmd_t                cmd_i,
  output swka_pkg::status_t             st_o,
  output logic [swka_pkg::DM_W-1:0]     res_members_o,
  output logic [swka_pkg::GT_W-1:0]     res_total_o,
  output logic                          res_dropped_o
);
  import swka_pkg::*;

  localparam int PTR_W  = $clog2(EVENT_DEPTH);
  localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int MEM_W  = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  localparam int ENTRIES = GROUPS * MEMBERS;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TOT_W  = $clog2(EVENT_DEPTH * ((1 << AMT_W) - 1) + 1);
  localparam int GM_W   = $clog2(MEMBERS + 1);
  localparam int TAG_W  = GRP_W + MEM_W + AMT_W;
  localparam int GW_W   = GM_W + TOT_W;
  localparam int SUM_W  = TIME_W + 1;

  // memories
  logic [TIME_W-1:0] fifo_time_mem [EVENT_DEPTH];
  logic [TAG_W-1:0]  fifo_tag_mem  [EVENT_DEPTH];
  logic [TOT_W-1:0]  member_mem    [ENTRIES];
  logic [GW_W-1:0]   group_mem     [GROUPS];

  // control registers
  logic [WL_W-1:0]  wl_q;
  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] clr_q;

  // item and read data registers
  logic [TIME_W-1:0]   time_q;
  logic [GRP_IN_W-1:0] grp_q;
  logic [MEM_IN_W-1:0] mem_q;
  logic [AMT_W-1:0]    amt_q;
  logic                grp_ok_q;
  logic                drop_q;
  logic [TIME_W-1:0]   ft_q;
  logic [TAG_W-1:0]    tag_q;
  logic [TOT_W-1:0]    mt_rd_q;
  logic [GW_W-1:0]     gw_rd_q;
  logic [DM_W-1:0]     res_dm_q;
  logic [GT_W-1:0]     res_gt_q;
  logic                res_drop_q;

  logic [GRP_W-1:0] item_grp, tag_grp, grp_rd_addr, grp_wr_addr;
  logic [MEM_W-1:0] tag_mem;
  logic [AMT_W-1:0] tag_amt;
  logic [IDX_W-1:0] item_idx, tag_idx, mt_rd_addr, mt_wr_addr;
  logic [TOT_W-1:0] mt_wr_data, gt_wr_data, gt_rd, tag_amt_x, item_amt_x;
  logic [GM_W-1:0]  gm_rd, gm_wr_data;
  logic             mt_we, gw_we, mt_re, gw_re;
  logic             fifo_full, fifo_empty;
  logic [PTR_W-1:0] head_nxt, tail_nxt;

  assign item_grp   = GRP_W'(grp_q);
  assign item_idx   = IDX_W'(32'(grp_q) * 32'(MEMBERS) + 32'(mem_q));
  assign tag_amt    = tag_q[AMT_W-1:0];
  assign tag_mem    = tag_q[AMT_W +: MEM_W];
  assign tag_grp    = tag_q[TAG_W-1 -: GRP_W];
  assign tag_idx    = IDX_W'(32'(tag_grp) * 32'(MEMBERS) + 32'(tag_mem));
  assign tag_amt_x  = TOT_W'(tag_amt);
  assign item_amt_x = TOT_W'(amt_q);
  assign gm_rd      = gw_rd_q[TOT_W +: GM_W];
  assign gt_rd      = gw_rd_q[TOT_W-1:0];

  assign fifo_full  = (cnt_q == CNT_W'(EVENT_DEPTH));
  assign fifo_empty = (cnt_q == '0);
  assign head_nxt   = (head_q == PTR_W'(EVENT_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_nxt   = (tail_q == PTR_W'(EVENT_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

  always_comb begin
    st_o            = '0;
    st_o.in_query   = in_kind_i;
    st_o.in_ok      = (32'(in_group_i) < 32'(GROUPS)) && (32'(in_member_i) < 32'(MEMBERS));
    st_o.fifo_full  = fifo_full;
    st_o.fifo_empty = fifo_empty;
    st_o.expire     = (SUM_W'(ft_q) + SUM_W'(wl_q)) <= SUM_W'(time_q);
    st_o.clr_last   = (clr_q == IDX_W'(ENTRIES - 1));
  end

  // table read ports
  assign mt_re       = cmd_i.add_rd || cmd_i.tag_rd;
  assign gw_re       = cmd_i.add_rd || cmd_i.tag_rd || cmd_i.fin_rd;
  assign mt_rd_addr  = cmd_i.tag_rd ? tag_idx : item_idx;
  assign grp_rd_addr = cmd_i.tag_rd ? tag_grp : item_grp;

  // table write ports: clear, add or retire
  always_comb begin
    mt_we       = cmd_i.clr || cmd_i.add_wr || cmd_i.exp_wr;
    gw_we       = cmd_i.add_wr || cmd_i.exp_wr;
    mt_wr_addr  = item_idx;
    grp_wr_addr = item_grp;
    mt_wr_data  = mt_rd_q + item_amt_x;
    gt_wr_data  = gt_rd + item_amt_x;
    gm_wr_data  = gm_rd;
    if (cmd_i.clr) begin
      mt_wr_addr  = clr_q;
      grp_wr_addr = GRP_W'(clr_q);
      mt_wr_data  = '0;
      gt_wr_data  = '0;
      gm_wr_data  = '0;
      gw_we       = (32'(clr_q) < 32'(GROUPS));
    end else if (cmd_i.exp_wr) begin
      mt_wr_addr  = tag_idx;
      grp_wr_addr = tag_grp;
      mt_wr_data  = (mt_rd_q > tag_amt_x) ? mt_rd_q - tag_amt_x : '0;
      gt_wr_data  = (gt_rd > tag_amt_x) ? gt_rd - tag_amt_x : '0;
      if (mt_rd_q != '0 && mt_rd_q <= tag_amt_x && gm_rd != '0) begin
        gm_wr_data = gm_rd - GM_W'(1);
      end
    end else if (mt_rd_q == '0 && amt_q != '0) begin
      // member becomes active in its group
      gm_wr_data = gm_rd + GM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mt_we) member_mem[mt_wr_addr] <= mt_wr_data;
    if (mt_re) mt_rd_q <= member_mem[mt_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (gw_we) group_mem[grp_wr_addr] <= {gm_wr_data, gt_wr_data};
    if (gw_re) gw_rd_q <= group_mem[grp_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      fifo_time_mem[tail_q] <= time_q;
      fifo_tag_mem[tail_q]  <= {item_grp, MEM_W'(mem_q), amt_q};
    end
    if (cmd_i.fifo_rd) begin
      ft_q  <= fifo_time_mem[head_q];
      tag_q <= fifo_tag_mem[head_q];
    end
  end

  // item capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      time_q   <= in_time_i;
      grp_q    <= in_group_i;
      mem_q    <= in_member_i;
      amt_q    <= in_amount_i;
      grp_ok_q <= (32'(in_group_i) < 32'(GROUPS));
      drop_q   <= !in_kind_i && st_o.in_ok && fifo_full;
    end
    if (cmd_i.out_load) begin
      res_dm_q   <= grp_ok_q ? DM_W'(gm_rd) : '0;
      res_gt_q   <= grp_ok_q ? GT_W'(gt_rd) : '0;
      res_drop_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WINDOW_RESET;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) wl_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_q <= st_o.clr_last ? '0 : clr_q + IDX_W'(1);
      if (cmd_i.add_wr) begin
        tail_q <= tail_nxt;
        cnt_q  <= cnt_q + CNT_W'(1);
      end else if (cmd_i.exp_wr) begin
        head_q <= head_nxt;
        cnt_q  <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign res_members_o = res_dm_q;
  assign res_total_o   = res_gt_q;
  assign res_dropped_o = res_drop_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(EVENT_DEPTH))
    else $error("fifo count beyond depth");

  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> !fifo_full)
    else $error("push into full fifo");

  a_retire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exp_wr |-> !fifo_empty)
    else $error("retire from empty fifo");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_empty || fifo_full) |-> (head_q == tail_q))
    else $error("fifo pointers disagree with count");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import swka_pkg::*;

  // block configuration as instantiated
  localparam int DEPTH     = EVENT_DEPTH_DEFAULT;
  localparam int GROUPS_N  = GROUPS_DEFAULT;
  localparam int MEMBERS_N = MEMBERS_DEFAULT;
  localparam int QPTR_W    = $clog2(DEPTH);

  // run control
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_WAIT  = 8;

  localparam longint unsigned TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [WL_W-1:0] WIN_MAX  = '1;

  typedef enum logic {
    KIND_BOOKING = 1'b0,
    KIND_QUERY   = 1'b1
  } kind_e;

  // one input beat
  typedef struct packed {
    kind_e               kind;
    logic [TIME_W-1:0]   event_time;
    logic [GRP_IN_W-1:0] group;
    logic [MEM_IN_W-1:0] member;
    logic [AMT_W-1:0]    amount;
  } beat_in_t;

  // one result beat
  typedef struct packed {
    logic [DM_W-1:0] distinct_members;
    logic [GT_W-1:0] group_total;
    logic            dropped;
  } counts_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [WL_W-1:0] cfg_wdata;

  swka_in_if  evt_if ();
  swka_out_if res_if ();

  sliding_window_key_aggregator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // window model: event fifo plus per member and per group sums
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]   q_time [DEPTH];
  logic [GRP_IN_W-1:0] q_grp  [DEPTH];
  logic [MEM_IN_W-1:0] q_mem  [DEPTH];
  logic [AMT_W-1:0]    q_amt  [DEPTH];
  logic [QPTR_W-1:0]   q_head, q_tail;
  int unsigned         q_count;

  int unsigned member_sum [GROUPS_N][MEMBERS_N];
  int unsigned group_sum  [GROUPS_N];
  int unsigned group_cnt  [GROUPS_N];
  longint unsigned win_len;

  // counts expected from the block, oldest first
  counts_t pending_counts [$];

  // handshake pressure, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // bookkeeping for the summary and the verdict
  int err_cnt   = 0;
  int n_checked = 0;
  int n_book    = 0;
  int n_drop    = 0;
  int n_query   = 0;
  int cycle_cnt = 0;

  // running booking time of the stimulus
  longint unsigned now_t;

  // model fifo pointer step with wrap
  function automatic logic [QPTR_W-1:0] q_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // apply one beat to the window model and return the counts it yields
  function automatic counts_t predict_counts(input beat_in_t b);
    counts_t             c;
    logic [GRP_IN_W-1:0] g;
    logic [MEM_IN_W-1:0] m;
    int unsigned         a, old_sum, new_sum;
    longint unsigned     now, front_end;
    c   = '0;
    now = 64'(b.event_time);
    if (b.kind == KIND_BOOKING) begin
      n_book++;
      if (q_count >= DEPTH) begin
        // full fifo: booking refused, expiry below still runs
        c.dropped = 1'b1;
        n_drop++;
      end else begin
        g = b.group;
        m = b.member;
        a = 32'(b.amount);
        // zero amount is queued but never makes a member count
        if (member_sum[g][m] == 0 && a != 0) group_cnt[g]++;
        member_sum[g][m] += a;
        group_sum[g]     += a;
        q_time[q_tail] = b.event_time;
        q_grp[q_tail]  = b.group;
        q_mem[q_tail]  = b.member;
        q_amt[q_tail]  = b.amount;
        q_tail = q_next(q_tail);
        q_count++;
      end
      // retire from the front only, stop at the first event still inside
      while (q_count > 0) begin
        front_end = 64'(q_time[q_head]);
        if (front_end + win_len > now) break;
        g = q_grp[q_head];
        m = q_mem[q_head];
        a = 32'(q_amt[q_head]);
        q_head = q_next(q_head);
        q_count--;
        old_sum = member_sum[g][m];
        new_sum = (old_sum > a) ? old_sum - a : 0;
        member_sum[g][m] = new_sum;
        if (old_sum != 0 && new_sum == 0 && group_cnt[g] > 0) group_cnt[g]--;
        group_sum[g] = (group_sum[g] > a) ? group_sum[g] - a : 0;
      end
    end else begin
      n_query++;
    end
    g = b.group;
    c.distinct_members = group_cnt[g][DM_W-1:0];
    c.group_total      = group_sum[g][GT_W-1:0];
    return c;
  endfunction

  function automatic beat_in_t booking(input longint unsigned t, input int g, input int m,
                                       input int a);
    beat_in_t b;
    b.kind       = KIND_BOOKING;
    b.event_time = t[TIME_W-1:0];
    b.group      = g[GRP_IN_W-1:0];
    b.member     = m[MEM_IN_W-1:0];
    b.amount     = a[AMT_W-1:0];
    return b;
  endfunction

  // a query carries junk in the fields it does not use
  function automatic beat_in_t query(input int g);
    beat_in_t    b;
    logic [63:0] r_time;
    logic [31:0] r_rest;
    r_time       = {$urandom(), $urandom()};
    r_rest       = $urandom();
    b.kind       = KIND_QUERY;
    b.event_time = r_time[TIME_W-1:0];
    b.group      = g[GRP_IN_W-1:0];
    b.member     = r_rest[MEM_IN_W-1:0];
    b.amount     = r_rest[MEM_IN_W +: AMT_W];
    return b;
  endfunction

  task automatic count_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("tb: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, every accepted beat checked against the model
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    counts_t want, got;
    if (res_if.valid && res_if.ready) begin
      got = {res_if.distinct_members, res_if.group_total, res_if.dropped};
      if (pending_counts.size() == 0) begin
        count_error($sformatf("unexpected result beat: members %0d total %0d dropped %0b",
                              got.distinct_members, got.group_total, got.dropped));
      end else begin
        want = pending_counts.pop_front();
        n_checked++;
        if (got.distinct_members !== want.distinct_members ||
            got.group_total !== want.group_total || got.dropped !== want.dropped) begin
          count_error($sformatf({"result %0d mismatch: members %0d/%0d total %0d/%0d ",
                                 "dropped %0b/%0b (expected/actual)"}, n_checked,
                                want.distinct_members, got.distinct_members,
                                want.group_total, got.group_total,
                                want.dropped, got.dropped));
        end
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_counts.size());
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one beat, hold it until taken, then record what it should give
  task automatic send_beat(input beat_in_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_if.valid      <= 1'b1;
    evt_if.kind       <= b.kind;
    evt_if.event_time <= b.event_time;
    evt_if.group      <= b.group;
    evt_if.member     <= b.member;
    evt_if.amount     <= b.amount;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    pending_counts.push_back(predict_counts(b));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    evt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // window register only changes while the block is idle
  task automatic set_window(input logic [WL_W-1:0] len);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    win_len = 64'(len);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset window: repeat members, zero amount, expiry boundary, late event stuck behind
  task automatic test_directed_basics();
    send_beat(query(0));                      // empty tables after the clearing pass
    send_beat(booking(100, 0, 5, 10));
    send_beat(booking(100, 0, 5, 1023));      // same member again, count stays
    send_beat(booking(100, 15, 255, 1));      // top group and member
    send_beat(booking(100, 3, 7, 0));         // zero amount, member not counted
    send_beat(query(3));
    send_beat(booking(100, 0, 0, 1));         // bottom member
    send_beat(booking(50, 0, 9, 4));          // older time queued behind newer ones
    send_beat(booking(86499, 0, 5, 2));       // one short of the window, nothing retires
    send_beat(booking(86500, 1, 1, 3));       // exactly on the boundary, front events go
    send_beat(booking(86600, 1, 2, 5));
    send_beat(booking(86560, 1, 3, 6));       // older than its predecessor
    send_beat(booking(172999, 2, 4, 7));      // front stops at 86600, 86560 stays
    send_beat(query(1));
    send_beat(booking(173000, 2, 4, 8));      // now both drop out
    send_beat(query(0));
    send_beat(query(1));
    send_beat(query(15));
    now_t = 173000;
  endtask

  // smallest, largest and zero window, plus the largest timestamp
  task automatic test_window_extremes();
    set_window(1);
    send_beat(booking(now_t + 1, 4, 10, 20));
    send_beat(booking(now_t + 1, 4, 11, 30)); // same time, one unit window keeps both
    send_beat(booking(now_t + 2, 4, 10, 40)); // the two older ones retire
    send_beat(query(4));
    now_t += 2;
    set_window(WIN_MAX);
    send_beat(booking(now_t, 5, 12, 100));
    send_beat(booking(now_t + WIN_MAX - 1, 5, 13, 200));  // nothing retires
    send_beat(booking(now_t + WIN_MAX, 5, 12, 300));      // oldest sits on the boundary
    send_beat(query(5));
    now_t += WIN_MAX;
    set_window(0);
    send_beat(booking(now_t, 6, 14, 500));    // a booking expires itself
    send_beat(booking(TIME_MAX, 15, 255, 1023));  // flushes the whole fifo
    send_beat(query(15));
    now_t = 0;
  endtask

  // fill the fifo to its depth, refuse bookings, then let a refused one empty it
  task automatic test_fifo_full();
    set_window(WIN_MAX);
    now_t = 1000;
    while (q_count < DEPTH)
      send_beat(booking(now_t, $urandom_range(0, GROUPS_N - 1), $urandom_range(0, 15),
                        $urandom_range(1, 1023)));
    send_beat(booking(now_t, 7, 1, 9));
    send_beat(query(7));
    send_beat(booking(now_t, 8, 200, 1023));
    set_window(1);
    send_beat(booking(now_t + 1, 9, 3, 77));  // refused, yet retires all the old events
    send_beat(booking(now_t + 1, 9, 3, 66));  // room again
    send_beat(query(9));
    now_t += 1;
  endtask

  // mostly ordered bookings over a short window, with queries, jumps and late times
  task automatic test_random(input int send_pct, input int recv_pct, input int beats);
    int win, r, mem, amt;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    win = $urandom_range(16, 600);
    set_window(win);
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_beat(query($urandom_range(0, GROUPS_N - 1)));
      end else begin
        r = $urandom_range(99);
        if (r < 3 && now_t >= 50) begin
          now_t -= $urandom_range(1, 50);     // late event
        end else if (r < 9) begin
          now_t += win + $urandom_range(0, win);  // jump, mass expiry
        end else begin
          now_t += $urandom_range(0, win / 8 + 1);
        end
        // small member pool so members come and go; sometimes the full range
        mem = ($urandom_range(99) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        amt = ($urandom_range(99) < 90) ? $urandom_range(1, 1023) : $urandom_range(0, 1023);
        send_beat(booking(now_t, $urandom_range(0, GROUPS_N - 1), mem, amt));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    evt_if.valid      = 1'b0;
    evt_if.kind       = 1'b0;
    evt_if.event_time = '0;
    evt_if.group      = '0;
    evt_if.member     = '0;
    evt_if.amount     = '0;
    res_if.ready      = 1'b0;
    q_head            = '0;
    q_tail            = '0;
    q_count           = 0;
    win_len           = 64'(WINDOW_RESET);
    now_t             = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_window_extremes();
    test_fifo_full();
    test_random(0, 0, 250);
    test_random(66, 0, 250);
    test_random(0, 66, 250);
    test_random(18, 18, 250);

    wait_drained();
    repeat (24) @(posedge clk_i);

    $display("tb: %0d bookings (%0d refused on a full fifo), %0d queries, %0d results checked",
             n_book, n_drop, n_query, n_checked);
    $display("tb: windows zero, one, all ones and random short; fifo filled to %0d; %0d faults",
             DEPTH, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/swka_pkg.sv
hdl/swka_in_if.sv
hdl/swka_out_if.sv
hdl/swka_ctrl.sv
hdl/swka_dp.sv
hdl/sliding_window_key_aggregator.sv
dv/tb.sv
